// ===== design/acb_pkg.sv =====
package acb_pkg;

	// angle units: 1/64 degree
	localparam int TURN_UNITS = 23040;
	localparam int QUAD_UNITS = 5760;

	// CORDIC datapath
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = 5;
	localparam int TRIG_W       = 34;
	localparam int Z_W          = 33;
	localparam int ZIN_W        = 30;
	localparam int REM_W        = 14;
	localparam int PT_W         = 36;
	localparam logic signed [TRIG_W-1:0] GAIN_START = 34'sd652032874;

	// rem * 2^30 / QUAD_UNITS equals rem * 2^23 / 45; ceil(2^41 / 45) with an
	// 18-bit shift is exact for every rem below QUAD_UNITS
	localparam int                   Z_RECIP_W = 36;
	localparam logic [Z_RECIP_W-1:0] Z_RECIP   = 36'd48867183457;
	localparam int                   Z_SHIFT   = 18;

	// arctangent table, 2^32 per turn
	localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// reduce a raw angle into [0, TURN_UNITS)
	function automatic logic [14:0] norm_angle(input logic signed [15:0] a);
		logic signed [16:0] w;
		w = {a[15], a};
		if (w >= 17'sd23040) begin
			w = w - 17'sd23040;
		end else if (w < -17'sd23040) begin
			w = w + 17'sd46080;
		end else if (w < 17'sd0) begin
			w = w + 17'sd23040;
		end
		return w[14:0];
	endfunction

	function automatic logic [1:0] quadrant(input logic [14:0] a);
		logic [1:0] q;
		if (a >= 15'd17280) begin
			q = 2'd3;
		end else if (a >= 15'd11520) begin
			q = 2'd2;
		end else if (a >= 15'd5760) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return q;
	endfunction

endpackage

// ===== design/acb_if.sv =====
interface acb_in_if;
	logic                valid;
	logic                ready;
	logic                start_new;
	logic signed [31:0]  center_x;
	logic signed [31:0]  center_y;
	logic [30:0]         radius;
	logic signed [15:0]  start_angle;
	logic signed [15:0]  end_angle;

	modport source (output valid, start_new, center_x, center_y, radius, start_angle,
		end_angle, input ready);
	modport sink (input valid, start_new, center_x, center_y, radius, start_angle,
		end_angle, output ready);
endinterface

interface acb_out_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  min_x;
	logic signed [31:0]  max_x;
	logic signed [31:0]  min_y;
	logic signed [31:0]  max_y;

	modport source (output valid, min_x, max_x, min_y, max_y, input ready);
	modport sink (input valid, min_x, max_x, min_y, max_y, output ready);
endinterface

// ===== design/acb_cordic.sv =====
// one CORDIC rotation lane, one iteration per enabled cycle
module acb_cordic (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic                                  en,
	input  logic [acb_pkg::ATAN_IDX_W-1:0]        idx,
	input  logic [acb_pkg::ZIN_W-1:0]             z_in,
	output logic signed [acb_pkg::TRIG_W-1:0]     x_out,
	output logic signed [acb_pkg::TRIG_W-1:0]     y_out
);

	logic signed [acb_pkg::TRIG_W-1:0] x_q, y_q;
	logic signed [acb_pkg::Z_W-1:0]    z_q;
	logic signed [acb_pkg::TRIG_W-1:0] x_sh, y_sh;
	logic signed [acb_pkg::Z_W-1:0]    atan_v;

	assign x_sh   = x_q >>> idx;
	assign y_sh   = y_q >>> idx;
	assign atan_v = $signed({1'b0, acb_pkg::ATAN_TABLE[idx]});

	// micro-rotation toward z = 0
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= acb_pkg::GAIN_START;
			y_q <= '0;
			z_q <= $signed({3'b000, z_in});
		end else if (en) begin
			if (z_q >= 0) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;

endmodule

// ===== design/arc_bounding_box_accumulator.sv =====
// Arc bounding box accumulator.
// arc_in takes one arc word: centre, radius (Q23.8), start and end angle in
// 1/64 degree, and start_new. box_out gives the running bounding box after
// every arc, one word per arc, in the same order.
// Sequence per arc: angle reduction, a phase in which the axis extremes
// go into the box and the CORDIC angles come from a reciprocal multiply,
// CORDIC_STEPS iterations of two CORDIC lanes, the four offsets on shared
// 32x17 multipliers, and the two end points. The next arc is taken in the
// cycle after the box word leaves, so the block works on one arc at a time.
// arc_in.ready is high only while the block is idle.
// Reset empties the box; the first arc after reset or with start_new sets
// the box to its own extent. Coordinates saturate to COORD_WIDTH bits and
// the low 32 bits are shown. A stalled receiver holds the box word on
// box_out and no new arc is taken until it leaves.
module arc_bounding_box_accumulator #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	acb_in_if.sink           arc_in,
	acb_out_if.source        box_out
);

	localparam int CW       = COORD_WIDTH;
	localparam int EXT_W    = 50;
	localparam int CNT_W    = acb_pkg::ATAN_IDX_W;
	localparam int DIV_CYC  = 4;
	localparam int MUL_CYC  = 8;
	localparam int PT_W_C   = acb_pkg::PT_W;
	localparam int ZP_W     = acb_pkg::REM_W + acb_pkg::Z_RECIP_W;
	localparam logic signed [EXT_W-1:0] SAT_HI =
		EXT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - 50'sd1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CORD = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ADD  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;

	// latched arc
	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        r_q;
	logic signed [15:0] sa_raw_q, ea_raw_q;
	logic [1:0]         sq_q, eq_q;
	logic [1:0]         kq_q;
	logic [2:0]         axis_n_q;

	// angle lanes: 0 = start, 1 = end
	logic [acb_pkg::REM_W-1:0] rem_q [2];
	logic [acb_pkg::ZIN_W-1:0] quo_nxt [2];
	logic [ZP_W-1:0]           z_prod [2];

	logic signed [acb_pkg::TRIG_W-1:0] cx_tr [2];
	logic signed [acb_pkg::TRIG_W-1:0] cy_tr [2];

	logic [47:0]             lo_q;
	logic signed [PT_W_C-1:0] off_q [4];

	// box
	logic                 empty_q;
	logic signed [CW-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;

	logic in_acc, out_acc;
	assign in_acc  = arc_in.valid && arc_in.ready;
	assign out_acc = box_out.valid && box_out.ready;

	// angle reduction
	logic [14:0] sa_n, ea_n;
	logic [1:0]  sq_n, eq_n;
	logic        wrap;
	logic [2:0]  n_axis;
	assign sa_n   = acb_pkg::norm_angle(sa_raw_q);
	assign ea_n   = acb_pkg::norm_angle(ea_raw_q);
	assign sq_n   = acb_pkg::quadrant(sa_n);
	assign eq_n   = acb_pkg::quadrant(ea_n);
	assign wrap   = (eq_n < sq_n) || ((eq_n == sq_n) && (sa_n > ea_n));
	assign n_axis = {1'b0, eq_n} - {1'b0, sq_n} + (wrap ? 3'd4 : 3'd0);

	function automatic logic [acb_pkg::REM_W-1:0] quad_rem(input logic [14:0] a,
		input logic [1:0] q);
		logic [14:0] d;
		case (q)
			2'd0: d = a;
			2'd1: d = a - 15'd5760;
			2'd2: d = a - 15'd11520;
			default: d = a - 15'd17280;
		endcase
		return d[acb_pkg::REM_W-1:0];
	endfunction

	// CORDIC start angle, floor(rem * 2^30 / QUAD_UNITS), by reciprocal multiply
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			z_prod[l]  = ZP_W'(rem_q[l]) * ZP_W'(acb_pkg::Z_RECIP);
			quo_nxt[l] = z_prod[l][acb_pkg::Z_SHIFT +: acb_pkg::ZIN_W];
		end
	end

	logic div_last, cord_last, mul_last, add_last;
	assign div_last  = (state_q == ST_DIV) && (cnt_q == CNT_W'(DIV_CYC - 1));
	assign cord_last = (state_q == ST_CORD) && (cnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign mul_last  = (state_q == ST_MUL) && (cnt_q == CNT_W'(MUL_CYC - 1));
	assign add_last  = (state_q == ST_ADD) && (cnt_q == CNT_W'(1));

	genvar gl;
	generate
		for (gl = 0; gl < 2; gl++) begin : g_lane
			acb_cordic u_cordic (
				.clk   (clk),
				.load  (div_last),
				.en    (state_q == ST_CORD),
				.idx   (cnt_q),
				.z_in  (quo_nxt[gl]),
				.x_out (cx_tr[gl]),
				.y_out (cy_tr[gl])
			);
		end
	endgenerate

	// quadrant folding and operand select for the shared multipliers
	logic [1:0]                        p_idx;
	logic [1:0]                        tq;
	logic signed [acb_pkg::TRIG_W-1:0] tx, ty, trig;
	assign p_idx = cnt_q[2:1];
	assign tq    = p_idx[1] ? eq_q : sq_q;
	assign tx    = cx_tr[p_idx[1]];
	assign ty    = cy_tr[p_idx[1]];
	always_comb begin
		case ({p_idx[0], tq})
			3'b000: trig = tx;
			3'b001: trig = -ty;
			3'b010: trig = -tx;
			3'b011: trig = ty;
			3'b100: trig = ty;
			3'b101: trig = tx;
			3'b110: trig = -ty;
			default: trig = -tx;
		endcase
	end

	logic [47:0]        lo_prod;
	logic signed [48:0] hi_prod;
	logic signed [65:0] full_prod;
	assign lo_prod   = 48'(r_q) * 48'(trig[16:0]);
	assign hi_prod   = $signed({1'b0, r_q}) * $signed(trig[33:17]);
	assign full_prod = $signed({hi_prod, 17'b0}) + $signed({18'b0, lo_q})
		+ 66'sd536870912;

	// point to merge this cycle
	logic                      pt_valid;
	logic signed [PT_W_C-1:0]  px, py, cx_e, cy_e, r_e;
	assign cx_e = PT_W_C'(cx_q);
	assign cy_e = PT_W_C'(cy_q);
	assign r_e  = $signed({5'b0, r_q});
	always_comb begin
		pt_valid = 1'b0;
		px       = cx_e;
		py       = cy_e;
		if (state_q == ST_DIV && axis_n_q != 3'd0) begin
			pt_valid = 1'b1;
			case (kq_q)
				2'd0: py = cy_e + r_e;
				2'd1: px = cx_e - r_e;
				2'd2: py = cy_e - r_e;
				default: px = cx_e + r_e;
			endcase
		end else if (state_q == ST_ADD) begin
			pt_valid = 1'b1;
			px       = cx_e + (cnt_q[0] ? off_q[2] : off_q[0]);
			py       = cy_e + (cnt_q[0] ? off_q[3] : off_q[1]);
		end
	end

	function automatic logic signed [CW-1:0] sat_c(input logic signed [PT_W_C-1:0] v);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(v);
		if (e > SAT_HI) begin
			e = SAT_HI;
		end else if (e < SAT_LO) begin
			e = SAT_LO;
		end
		return e[CW-1:0];
	endfunction

	logic signed [CW-1:0] px_s, py_s;
	assign px_s = sat_c(px);
	assign py_s = sat_c(py);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			empty_q  <= 1'b1;
			axis_n_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_NORM;
						if (arc_in.start_new) begin
							empty_q <= 1'b1;
						end
					end
				end
				ST_NORM: begin
					state_q  <= ST_DIV;
					cnt_q    <= '0;
					axis_n_q <= n_axis;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (axis_n_q != 3'd0) begin
						axis_n_q <= axis_n_q - 3'd1;
					end
					if (div_last) begin
						state_q <= ST_CORD;
						cnt_q   <= '0;
					end
				end
				ST_CORD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cord_last) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (mul_last) begin
						state_q <= ST_ADD;
						cnt_q   <= '0;
					end
				end
				ST_ADD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (add_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_acc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (pt_valid) begin
				empty_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q     <= arc_in.center_x;
			cy_q     <= arc_in.center_y;
			r_q      <= arc_in.radius;
			sa_raw_q <= arc_in.start_angle;
			ea_raw_q <= arc_in.end_angle;
		end
		if (state_q == ST_NORM) begin
			sq_q     <= sq_n;
			eq_q     <= eq_n;
			kq_q     <= sq_n;
			rem_q[0] <= quad_rem(sa_n, sq_n);
			rem_q[1] <= quad_rem(ea_n, eq_n);
		end
		if (state_q == ST_DIV) begin
			if (axis_n_q != 3'd0) begin
				kq_q <= kq_q + 2'd1;
			end
		end
		if (state_q == ST_MUL) begin
			if (!cnt_q[0]) begin
				lo_q <= lo_prod;
			end else begin
				off_q[p_idx] <= full_prod[65:30];
			end
		end
		// widen the box
		if (pt_valid) begin
			if (empty_q) begin
				bmin_x_q <= px_s;
				bmax_x_q <= px_s;
				bmin_y_q <= py_s;
				bmax_y_q <= py_s;
			end else begin
				if (px_s < bmin_x_q) bmin_x_q <= px_s;
				if (px_s > bmax_x_q) bmax_x_q <= px_s;
				if (py_s < bmin_y_q) bmin_y_q <= py_s;
				if (py_s > bmax_y_q) bmax_y_q <= py_s;
			end
		end
	end

	logic signed [EXT_W-1:0] e_min_x, e_max_x, e_min_y, e_max_y;
	assign e_min_x = EXT_W'(bmin_x_q);
	assign e_max_x = EXT_W'(bmax_x_q);
	assign e_min_y = EXT_W'(bmin_y_q);
	assign e_max_y = EXT_W'(bmax_y_q);

	assign arc_in.ready  = (state_q == ST_IDLE);
	assign box_out.valid = (state_q == ST_DONE);
	assign box_out.min_x = e_min_x[31:0];
	assign box_out.max_x = e_max_x[31:0];
	assign box_out.min_y = e_min_y[31:0];
	assign box_out.max_y = e_max_y[31:0];

endmodule

// ===== design/acb_checker.sv =====
module acb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] min_x,
	input logic signed [31:0] max_x,
	input logic signed [31:0] min_y,
	input logic signed [31:0] max_y
);

	// a pending box word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("box word dropped while stalled");

	// a stalled box word keeps its min_x and max_y values
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(min_x) && $stable(max_y)))
		else $error("box word changed while stalled");

	// one arc at a time: busy right after a word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !out_valid))
		else $error("arc taken while busy");

	// a delivered box is well formed
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((min_x <= max_x) && (min_y <= max_y)))
		else $error("box minimum above maximum");

endmodule

bind arc_bounding_box_accumulator acb_checker u_acb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (arc_in.valid),
	.in_ready  (arc_in.ready),
	.out_valid (box_out.valid),
	.out_ready (box_out.ready),
	.min_x     (box_out.min_x),
	.max_x     (box_out.max_x),
	.min_y     (box_out.min_y),
	.max_y     (box_out.max_y)
);

// ===== test/arc_bounding_box_accumulator_test.sv =====
module arc_bounding_box_accumulator_test;

	localparam int STEPS   = 16;
	localparam int CW      = 32;
	localparam int WD_MAX  = 5000;

	typedef struct {
		logic        start_new;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [30:0] r;
		logic [15:0] sa;
		logic [15:0] ea;
	} arc_t;

	typedef struct {
		logic [31:0] min_x;
		logic [31:0] max_x;
		logic [31:0] min_y;
		logic [31:0] max_y;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	acb_in_if  arc_in ();
	acb_out_if box_out ();

	arc_bounding_box_accumulator #(.CORDIC_STEPS(STEPS), .COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .arc_in(arc_in), .box_out(box_out)
	);

	always #5 clk = ~clk;

	// running box model
	logic        bm_empty;
	longint      bm_min_x, bm_max_x, bm_min_y, bm_max_y;
	box_t        box_queue[$];
	int          fail_cnt = 0;
	int          idle_cycles = 0;
	bit          hold_off = 1'b0;
	bit          bursty = 1'b1;

	function automatic longint clamp_coord(longint v);
		longint hi;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic void widen_box(longint px, longint py);
		px = clamp_coord(px);
		py = clamp_coord(py);
		if (bm_empty) begin
			bm_min_x = px; bm_max_x = px;
			bm_min_y = py; bm_max_y = py;
			bm_empty = 1'b0;
		end else begin
			if (px < bm_min_x) bm_min_x = px;
			if (px > bm_max_x) bm_max_x = px;
			if (py < bm_min_y) bm_min_y = py;
			if (py > bm_max_y) bm_max_y = py;
		end
	endfunction

	function automatic int wrap_angle(logic [15:0] raw);
		int a;
		a = int'($signed(raw)) % acb_pkg::TURN_UNITS;
		if (a < 0) a += acb_pkg::TURN_UNITS;
		return a;
	endfunction

	// rim point at a normalised angle
	function automatic void widen_rim(longint cx, longint cy, longint r, int ang);
		int     q;
		longint z, x, y, nx, c, s;
		q = ang / acb_pkg::QUAD_UNITS;
		z = (longint'(ang - q * acb_pkg::QUAD_UNITS) <<< 30) / acb_pkg::QUAD_UNITS;
		x = 652032874;
		y = 0;
		for (int i = 0; i < STEPS && i < acb_pkg::ATAN_ENTRIES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i);
				z -= longint'(acb_pkg::ATAN_TABLE[i]);
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i);
				z += longint'(acb_pkg::ATAN_TABLE[i]);
			end
			x = nx;
		end
		case (q & 3)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		widen_box(cx + ((r * c + (64'sd1 <<< 29)) >>> 30),
			cy + ((r * s + (64'sd1 <<< 29)) >>> 30));
	endfunction

	function automatic box_t predict_box(arc_t a);
		longint cx, cy, r;
		int     sa, ea, sq, eq;
		box_t   b;
		cx = longint'($signed(a.cx));
		cy = longint'($signed(a.cy));
		r  = longint'({1'b0, a.r});
		sa = wrap_angle(a.sa);
		ea = wrap_angle(a.ea);
		sq = sa / acb_pkg::QUAD_UNITS;
		eq = ea / acb_pkg::QUAD_UNITS;
		if (a.start_new) bm_empty = 1'b1;
		if (eq < sq || (eq == sq && sa > ea)) eq += 4;
		for (int k = sq; k < eq; k++) begin
			case (k & 3)
				0: widen_box(cx, cy + r);
				1: widen_box(cx - r, cy);
				2: widen_box(cx, cy - r);
				default: widen_box(cx + r, cy);
			endcase
		end
		widen_rim(cx, cy, r, sa);
		widen_rim(cx, cy, r, ea);
		b.min_x = bm_min_x[31:0]; b.max_x = bm_max_x[31:0];
		b.min_y = bm_min_y[31:0]; b.max_y = bm_max_y[31:0];
		return b;
	endfunction

	// drive one arc word and wait for acceptance
	task automatic send_arc(arc_t a);
		int gap;
		@(negedge clk);
		if (bursty && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 30);
			repeat (gap) @(negedge clk);
		end
		arc_in.valid       <= 1'b1;
		arc_in.start_new   <= a.start_new;
		arc_in.center_x    <= a.cx;
		arc_in.center_y    <= a.cy;
		arc_in.radius      <= a.r;
		arc_in.start_angle <= a.sa;
		arc_in.end_angle   <= a.ea;
		@(posedge clk);
		while (!arc_in.ready) @(posedge clk);
		box_queue.push_back(predict_box(a));
		@(negedge clk);
		arc_in.valid <= 1'b0;
	endtask

	function automatic arc_t rand_arc(int rmax_log);
		arc_t a;
		a.start_new = ($urandom_range(0, 5) == 0);
		a.cx = $urandom();
		a.cy = $urandom();
		if ($urandom_range(0, 1)) begin
			a.cx = $signed(a.cx) >>> $urandom_range(0, 31);
			a.cy = $signed(a.cy) >>> $urandom_range(0, 31);
		end
		a.r = 31'($urandom() >> (32 - rmax_log));
		if ($urandom_range(0, 3) == 0) begin
			a.sa = 16'($urandom()); a.ea = 16'($urandom());
		end else begin
			a.sa = 16'($signed($urandom_range(0, 46080)) - 23040);
			a.ea = 16'($signed($urandom_range(0, 46080)) - 23040);
		end
		return a;
	endfunction

	function automatic arc_t mk(int sn, int cx, int cy, int r, int sa, int ea);
		arc_t a;
		a.start_new = (sn != 0); a.cx = cx; a.cy = cy; a.r = 31'(r);
		a.sa = 16'(sa); a.ea = 16'(ea);
		return a;
	endfunction

	task automatic wait_drained();
		while (box_queue.size() != 0) @(negedge clk);
	endtask

	// extremes, quadrant wrap, equal angles, saturation
	task automatic test_directed();
		send_arc(mk(1, 0, 0, 256, 0, 5760));
		send_arc(mk(0, 0, 0, 256, 0, 0));
		send_arc(mk(1, 0, 0, 256, 1000, 500));
		send_arc(mk(0, 100, 100, 1000, -100, 100));
		send_arc(mk(1, 0, 0, 256, 23040, -23040));
		send_arc(mk(0, 0, 0, 256, 32'h7fff, 32'h8000));
		send_arc(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 11520));
		send_arc(mk(1, 32'h80000000, 32'h80000000, 32'h7fffffff, 11520, 0));
		send_arc(mk(0, 0, 0, 0, 5759, 5761));
		send_arc(mk(1, -5000, 7000, 12345, 17280, 17279));
		send_arc(mk(1, 0, 0, 32'h7fffffff, -23040, 23040));
		send_arc(mk(0, 32'hffffffff, 1, 1, 32'hffff, 1));
		send_arc(mk(1, 0, 0, 65536, 2880, 20160));
		send_arc(mk(0, 0, 0, 65536, 8640, 14400));
		wait_drained();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_arc(rand_arc(($urandom_range(0, 1)) ? 31 : $urandom_range(1, 20)));
	endtask

	// receiver holds off while arcs keep coming
	task automatic test_backpressure();
		hold_off = 1'b1;
		bursty = 1'b0;
		for (int i = 0; i < 4; i++) send_arc(rand_arc(20));
		bursty = 1'b1;
		wait (!hold_off);
		wait_drained();
	endtask

	// receiver stall pattern
	always begin
		@(negedge clk);
		if (hold_off) begin
			box_out.ready <= 1'b0;
			repeat (300) @(negedge clk);
			hold_off = 1'b0;
		end else if ($urandom_range(0, 9) < 3) begin
			box_out.ready <= 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
		end else begin
			box_out.ready <= 1'b1;
			repeat ($urandom_range(0, 60)) @(negedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		box_t e;
		if (arst_n && box_out.valid && box_out.ready) begin
			if (box_queue.size() == 0) begin
				$error("box word with none expected");
				fail_cnt++;
			end else begin
				e = box_queue.pop_front();
				if (box_out.min_x !== e.min_x) begin
					$error("min_x exp %h got %h", e.min_x, box_out.min_x); fail_cnt++;
				end
				if (box_out.max_x !== e.max_x) begin
					$error("max_x exp %h got %h", e.max_x, box_out.max_x); fail_cnt++;
				end
				if (box_out.min_y !== e.min_y) begin
					$error("min_y exp %h got %h", e.min_y, box_out.min_y); fail_cnt++;
				end
				if (box_out.max_y !== e.max_y) begin
					$error("max_y exp %h got %h", e.max_y, box_out.max_y); fail_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((arc_in.valid && arc_in.ready) || (box_out.valid && box_out.ready)
				|| hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arc_in.valid = 1'b0;
		arc_in.start_new = 1'b0;
		arc_in.center_x = '0;
		arc_in.center_y = '0;
		arc_in.radius = '0;
		arc_in.start_angle = '0;
		arc_in.end_angle = '0;
		box_out.ready = 1'b0;
		bm_empty = 1'b1;
		bm_min_x = 0; bm_max_x = 0; bm_min_y = 0; bm_max_y = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(500);
		wait_drained();
		test_random(530);
		wait_drained();
		repeat (100) @(negedge clk);
		if (fail_cnt == 0 && box_queue.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
